>>> sv/pcfl_pkg.sv
// shared types and codes for the per-cpu page free-list allocator
package pcfl_pkg;

  typedef enum logic {
    CMD_FREE  = 1'b0,
    CMD_ALLOC = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_t;

  localparam logic REG_REGION_BASE = 1'b0;
  localparam logic REG_REGION_TOP  = 1'b1;

  localparam logic [31:0] REGION_BASE_RST = 32'h8000_0000;
  localparam logic [31:0] REGION_TOP_RST  = 32'h8800_0000;

  // controller to datapath
  typedef struct packed {
    logic capture;     // take the request fields
    logic eval;        // address check or source search
    logic link_read;   // read the link of the chosen head
    logic push;        // commit a free and load the response
    logic pop;         // commit an allocate and load the response
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_alloc;
  } dp_stat_t;

endpackage

>>> sv/per_cpu_page_free_list_allocator.sv
// top level of the per-cpu page free-list allocator with stealing
//
// Request channel (req_valid/req_stall) carries cmd, cpu_id and page_addr; a
// transfer happens when req_valid is high and req_stall is low. A free pushes
// page_addr onto the list of cpu_id after checking alignment, the region and
// the link store size; an allocate pops the own list or steals the head of the
// lowest-numbered other non-empty list. Every request gives one response on
// the rsp_valid/rsp_stall channel: status, granted_addr, source_cpu.
// Requests are handled one at a time: a free is loaded into the response
// register after its check and commit, an allocate after priority search,
// registered link memory read and head update. The link memory has one
// port, touched at most once per request. A new request is taken as soon
// as the previous one has been loaded into the response register, so it
// overlaps a stalled response; its commit waits until that response has
// been transferred. The config channel (cfg_valid/cfg_ready, always ready)
// writes region_base (index 0) and region_top (index 1); the user must
// write them only while the block is idle, which the block itself does not
// enforce. Reset empties all lists and restores the default region; the
// link memory is not cleared and needs no start-up pass.
module per_cpu_page_free_list_allocator #(
  parameter int NUM_CPUS   = 8,
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        cmd,
  input  logic [2:0]  cpu_id,
  input  logic [31:0] page_addr,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [31:0] granted_addr,
  output logic [2:0]  source_cpu,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import pcfl_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready = 1'b1;

  pcfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  pcfl_datapath #(
    .NUM_CPUS   (NUM_CPUS),
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .dp_cmd       (dp_cmd),
    .dp_stat      (dp_stat),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .cpu_id       (cpu_id),
    .page_addr    (page_addr),
    .status       (status),
    .granted_addr (granted_addr),
    .source_cpu   (source_cpu)
  );

  // one request in flight: a transfer always closes the request port
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request port open right after a transfer");

  // a response is only loaded while a request is being finished
  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response appeared without a request in progress");

  // failed operations grant nothing
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status == ST_OOM || status == ST_BAD_ADDR)) |->
      (granted_addr == '0 && source_cpu == '0))
    else $error("failed operation carries a grant");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_OK || status == ST_OOM || status == ST_BAD_ADDR))
    else $error("undefined status code");

endmodule

>>> sv/pcfl_datapath.sv
// datapath: region registers, list heads, link memory and response register
module pcfl_datapath #(
  parameter int NUM_CPUS   = 8,
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  pcfl_pkg::dp_cmd_t  dp_cmd,
  output pcfl_pkg::dp_stat_t dp_stat,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               cmd,
  input  logic [2:0]         cpu_id,
  input  logic [31:0]        page_addr,
  output logic [1:0]         status,
  output logic [31:0]        granted_addr,
  output logic [2:0]         source_cpu
);
  import pcfl_pkg::*;

  localparam int CW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int SW  = $clog2(NUM_PAGES);
  localparam int HW  = $clog2(NUM_PAGES + 1);
  localparam int PS  = $clog2(PAGE_BYTES);
  localparam int PNW = 33 - PS;

  // requesting cpu wrapped into range
  function automatic logic [CW-1:0] cpu_wrap(input logic [2:0] v);
    logic [6:0] t;
    t = {4'd0, v};
    for (int k = 0; k < 8; k++) begin
      if (t >= 7'(NUM_CPUS)) t = t - 7'(NUM_CPUS);
    end
    return CW'(t);
  endfunction

  logic [31:0]   region_base;
  logic [31:0]   region_top;
  logic [PNW-1:0] first_page;

  logic          op_alloc;
  logic [CW-1:0] op_cpu;
  logic [31:0]   op_addr;

  logic [HW-1:0] heads [NUM_CPUS];
  logic [HW-1:0] link_mem [NUM_PAGES];
  logic [HW-1:0] link_rd;

  logic          addr_ok;
  logic [SW-1:0] slot;
  logic [CW-1:0] src;
  logic          found;
  logic [HW-1:0] src_head;

  logic [NUM_CPUS-1:0] nonempty;
  logic [CW-1:0]       pick;
  logic                pick_found;
  logic [PNW-1:0]      pn_diff;
  logic                chk_ok;
  logic [HW-1:0]       head_dec;
  logic [SW-1:0]       pop_slot;
  logic [32:0]         pop_page;

  status_t       status_q;
  logic [31:0]   granted_q;
  logic [2:0]    source_q;

  assign dp_stat.is_alloc = op_alloc;

  // config registers and first whole page of the region
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= REGION_BASE_RST;
      region_top  <= REGION_TOP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REGION_BASE: region_base <= cfg_data;
        REG_REGION_TOP:  region_top  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    first_page <= PNW'(({1'b0, region_base} + 33'(PAGE_BYTES - 1)) >> PS);
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      op_alloc <= (cmd == CMD_ALLOC);
      op_cpu   <= cpu_wrap(cpu_id);
      op_addr  <= page_addr;
    end
  end

  // source search: own list first, then the lowest other non-empty list
  always_comb begin
    for (int i = 0; i < NUM_CPUS; i++) begin
      nonempty[i] = (heads[i] != '0);
    end
    pick       = op_cpu;
    pick_found = nonempty[op_cpu];
    if (!nonempty[op_cpu]) begin
      for (int i = NUM_CPUS - 1; i >= 0; i--) begin
        if (nonempty[i] && (CW'(i) != op_cpu)) begin
          pick       = CW'(i);
          pick_found = 1'b1;
        end
      end
    end
  end

  // free address check
  always_comb begin
    pn_diff = PNW'({1'b0, op_addr[31:PS]}) - first_page;
    chk_ok  = (op_addr[PS-1:0] == '0) && (op_addr >= region_base) &&
              (op_addr < region_top) && (33'(pn_diff) < 33'(NUM_PAGES));
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.eval) begin
      addr_ok  <= chk_ok;
      slot     <= SW'(pn_diff);
      src      <= pick;
      found    <= pick_found;
      src_head <= heads[pick];
    end
  end

  assign head_dec = src_head - HW'(1);
  assign pop_slot = SW'(head_dec);
  assign pop_page = 33'(first_page) + 33'(pop_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CPUS; i++) heads[i] <= '0;
    end else if (dp_cmd.push && addr_ok) begin
      heads[op_cpu] <= HW'(slot) + HW'(1);
    end else if (dp_cmd.pop && found) begin
      heads[src] <= link_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.push && addr_ok) link_mem[slot] <= heads[op_cpu];
    if (dp_cmd.link_read && found) link_rd <= link_mem[pop_slot];
  end

  // response register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (dp_cmd.push) begin
      status_q  <= addr_ok ? ST_OK : ST_BAD_ADDR;
      granted_q <= '0;
      source_q  <= '0;
    end else if (dp_cmd.pop) begin
      if (found) begin
        status_q  <= ST_OK;
        granted_q <= 32'(pop_page << PS);
        source_q  <= 3'(src);
      end else begin
        status_q  <= ST_OOM;
        granted_q <= '0;
        source_q  <= '0;
      end
    end
  end

  assign status       = status_q;
  assign granted_addr = granted_q;
  assign source_cpu   = source_q;

endmodule

>>> sv/pcfl_ctrl.sv
// controller: sequences one request through check or search, link access and commit
module pcfl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  input  pcfl_pkg::dp_stat_t dp_stat,
  output pcfl_pkg::dp_cmd_t  dp_cmd
);
  import pcfl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PUSH,
    S_READ,
    S_POP
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;
  logic   rsp_free;

  // response register can take a new result this cycle
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    dp_cmd     = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        dp_cmd.capture = req_valid;
        if (req_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        dp_cmd.eval = 1'b1;
        state_next  = dp_stat.is_alloc ? S_READ : S_PUSH;
      end
      S_PUSH: begin
        dp_cmd.push = rsp_free;
        if (rsp_free) state_next = S_IDLE;
      end
      S_READ: begin
        dp_cmd.link_read = 1'b1;
        state_next       = S_POP;
      end
      S_POP: begin
        dp_cmd.pop = rsp_free;
        if (rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    rsp_valid_next = (dp_cmd.push || dp_cmd.pop) ? 1'b1 : (rsp_valid && rsp_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule
